// ===== sv/mhc_pkg.sv =====
// Package for the magnetometer heading calibrator.
// Holds opcodes, register indexes, controller states, command/status structs
// and the arctangent table. No dependencies.
package mhc_pkg;

    // default parameter values
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int SCALE_FRAC_BITS_DEF = 14;

    // angle accumulator width: tenths of a degree times 65536, signed
    localparam int ANG_W = 30;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_START   = 2'd1,
        OP_SAMPLE  = 2'd2,
        OP_FINISH  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_OFS_X = 3'd0,
        CFG_OFS_Y = 3'd1,
        CFG_SCL_X = 3'd2,
        CFG_SCL_Y = 3'd3,
        CFG_TRIM  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_X,
        S_LOAD_Y,
        S_DIV_Y,
        S_APPLY,
        S_MUL_X,
        S_MUL_Y,
        S_ROUND,
        S_CINIT,
        S_CORDIC,
        S_FINAL
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_init_x;
        logic div_step;
        logic div_init_y;
        logic apply_cal;
        logic mul_x;
        logic mul_y;
        logic round;
        logic cordic_init;
        logic cordic_step;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_stat;

    // atan(2^-i) in tenths of a degree times 65536
    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 30'd29491200;
            5'd1:  v = 30'd17409672;
            5'd2:  v = 30'd9198793;
            5'd3:  v = 30'd4669451;
            5'd4:  v = 30'd2343786;
            5'd5:  v = 30'd1173036;
            5'd6:  v = 30'd586661;
            5'd7:  v = 30'd293348;
            5'd8:  v = 30'd146676;
            5'd9:  v = 30'd73339;
            5'd10: v = 30'd36669;
            5'd11: v = 30'd18335;
            5'd12: v = 30'd9167;
            5'd13: v = 30'd4584;
            5'd14: v = 30'd2292;
            5'd15: v = 30'd1146;
            5'd16: v = 30'd573;
            5'd17: v = 30'd286;
            5'd18: v = 30'd143;
            5'd19: v = 30'd72;
            5'd20: v = 30'd36;
            5'd21: v = 30'd18;
            5'd22: v = 30'd9;
            5'd23: v = 30'd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/mhc_ctrl.sv =====
// Controller for the magnetometer heading calibrator.
// Sequences divider, multiplier, CORDIC and output load. Uses mhc_pkg.
module mhc_ctrl
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
    localparam int NUM_W = 18 + SCALE_FRAC_BITS,
    localparam int IDX_W = $clog2(CORDIC_STEPS),
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_op,
    output logic             o_stall,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_step
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_step  = r_cnt[IDX_W-1:0];

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (t_op'(i_op) == OP_FINISH) begin
                        o_cmd.div_init_x = 1'b1;
                        n_state = S_DIV_X;
                    end else begin
                        n_state = S_MUL_X;
                    end
                end
            end
            S_DIV_X: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LOAD_Y;
                end
            end
            S_LOAD_Y: begin
                o_cmd.div_init_y = 1'b1;
                n_state = S_DIV_Y;
            end
            S_DIV_Y: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply_cal = 1'b1;
                n_state = S_MUL_X;
            end
            S_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/mhc_dp.sv =====
// Datapath for the magnetometer heading calibrator.
// Config registers, ranges, scale divider, correction multiplier, CORDIC and
// output register. Uses mhc_pkg.
module mhc_dp
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
    localparam int NUM_W = 18 + SCALE_FRAC_BITS,
    localparam int IDX_W = $clog2(CORDIC_STEPS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic [1:0]          i_op,
    input  logic signed [15:0]  i_raw_x,
    input  logic signed [15:0]  i_raw_y,
    input  t_cmd                i_cmd,
    input  logic [IDX_W-1:0]    i_step,
    output t_stat               o_stat,
    input  logic                i_stall,
    output logic                o_valid,
    output logic signed [17:0]  o_cal_x,
    output logic signed [17:0]  o_cal_y,
    output logic [11:0]         o_heading,
    output logic signed [15:0]  o_range_min_x,
    output logic signed [15:0]  o_range_max_x,
    output logic signed [15:0]  o_range_min_y,
    output logic signed [15:0]  o_range_max_y,
    output logic                o_calibrated
);

    localparam int F      = SCALE_FRAC_BITS;
    localparam int XY_W   = 29;
    localparam logic [15:0] SCALE_ONE = (F >= 16) ? 16'hFFFF : 16'(1 << F);

    // config and calibration state
    logic signed [15:0] r_ofs_x, r_ofs_y, r_act_ofs_x, r_act_ofs_y;
    logic [15:0]        r_scl_x, r_scl_y, r_act_scl_x, r_act_scl_y;
    logic signed [12:0] r_trim;
    logic               r_cal_done;
    logic signed [15:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;

    // item and working registers
    t_op                r_op;
    logic signed [15:0] r_rx, r_ry;
    logic [NUM_W-1:0]   r_num, r_quo;
    logic [16:0]        r_rem;
    logic [16:0]        r_dvs;
    logic               r_dzero;
    logic [15:0]        r_new_sx;
    logic signed [33:0] r_prod;
    logic signed [17:0] r_cx, r_cy;
    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic               r_zero;
    logic               r_out_valid;

    // spans, clamped at zero for an empty range
    logic signed [16:0] span_x_s, span_y_s;
    logic [15:0]        span_x, span_y;
    assign span_x_s = 17'(r_hi_x) - 17'(r_lo_x);
    assign span_y_s = 17'(r_hi_y) - 17'(r_lo_y);
    assign span_x   = span_x_s[16] ? 16'd0 : span_x_s[15:0];
    assign span_y   = span_y_s[16] ? 16'd0 : span_y_s[15:0];

    function automatic logic signed [15:0] mid(input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
        logic signed [17:0] s;
        s = 18'(lo) + 18'(hi) + 18'sd1;
        return s[16:1];
    endfunction

    function automatic logic [NUM_W-1:0] scale_num(input logic [15:0] d,
                                                   input logic [15:0] e);
        logic [NUM_W-1:0] s;
        s = NUM_W'({1'b0, d} + {1'b0, e});
        return (s << F) + NUM_W'(d);
    endfunction

    function automatic logic [15:0] scale_sat(input logic dz,
                                              input logic [NUM_W-1:0] q);
        logic [15:0] v;
        if (dz)
            v = SCALE_ONE;
        else if (|q[NUM_W-1:16])
            v = 16'hFFFF;
        else
            v = q[15:0];
        return v;
    endfunction

    function automatic logic signed [17:0] round_sat(input logic signed [33:0] p);
        logic signed [34:0] r;
        logic signed [34:0] q;
        logic signed [17:0] v;
        r = 35'(p) + (35'sd1 <<< (F - 1));
        q = r >>> F;
        if (q > 35'sd131071)
            v = 18'sd131071;
        else if (q < -35'sd131072)
            v = -18'sd131072;
        else
            v = q[17:0];
        return v;
    endfunction

    function automatic logic signed [14:0] wrap(input logic signed [14:0] h);
        logic signed [14:0] v;
        v = h;
        if (v < 0)
            v = v + 15'sd3600;
        else if (v >= 15'sd3600)
            v = v - 15'sd3600;
        return v;
    endfunction

    // active correction values
    logic signed [15:0] use_ofs_x, use_ofs_y;
    logic [15:0]        use_scl_x, use_scl_y;
    assign use_ofs_x = r_cal_done ? r_act_ofs_x : r_ofs_x;
    assign use_ofs_y = r_cal_done ? r_act_ofs_y : r_ofs_y;
    assign use_scl_x = r_cal_done ? r_act_scl_x : r_scl_x;
    assign use_scl_y = r_cal_done ? r_act_scl_y : r_scl_y;

    // one shared multiplier, X then Y
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    always_comb begin
        if (i_cmd.mul_x) begin
            mul_a = 17'(r_rx) - 17'(use_ofs_x);
            mul_b = $signed({1'b0, use_scl_x});
        end else begin
            mul_a = 17'(r_ry) - 17'(use_ofs_y);
            mul_b = $signed({1'b0, use_scl_y});
        end
    end

    // divider step
    logic [17:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});

    // CORDIC step terms
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0] at;
    assign xs = r_x >>> i_step;
    assign ys = r_y >>> i_step;
    assign at = $signed(atan_entry(5'(i_step)));

    // final angle and trim
    logic signed [ANG_W-1:0] z_rnd;
    logic signed [14:0]      ang, h_sum, h_wrap;
    assign z_rnd  = r_z + ANG_W'(32768);
    assign ang    = r_zero ? 15'sd0 : 15'($signed(z_rnd[ANG_W-1:16]));
    assign h_sum  = ang + 15'(r_trim);
    assign h_wrap = wrap(wrap(h_sum));

    // control state: config, calibration, ranges, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_x     <= '0;
            r_ofs_y     <= '0;
            r_scl_x     <= 16'd16384;
            r_scl_y     <= 16'd16384;
            r_trim      <= '0;
            r_cal_done  <= 1'b0;
            r_act_ofs_x <= '0;
            r_act_ofs_y <= '0;
            r_act_scl_x <= 16'd16384;
            r_act_scl_y <= 16'd16384;
            r_lo_x      <= 16'sd32767;
            r_hi_x      <= -16'sd32768;
            r_lo_y      <= 16'sd32767;
            r_hi_y      <= -16'sd32768;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OFS_X: r_ofs_x <= $signed(i_cfg_data);
                    CFG_OFS_Y: r_ofs_y <= $signed(i_cfg_data);
                    CFG_SCL_X: r_scl_x <= i_cfg_data;
                    CFG_SCL_Y: r_scl_y <= i_cfg_data;
                    CFG_TRIM:  r_trim  <= $signed(i_cfg_data[12:0]);
                    default: ;
                endcase
            end
            if (i_cmd.apply_cal) begin
                r_act_ofs_x <= mid(r_lo_x, r_hi_x);
                r_act_ofs_y <= mid(r_lo_y, r_hi_y);
                r_act_scl_x <= r_new_sx;
                r_act_scl_y <= scale_sat(r_dzero, r_quo);
                r_cal_done  <= 1'b1;
            end
            // restart or fold the ranges
            if (i_cmd.round) begin
                if (r_op == OP_START) begin
                    r_lo_x <= r_rx;
                    r_hi_x <= r_rx;
                    r_lo_y <= r_ry;
                    r_hi_y <= r_ry;
                end else if (r_op == OP_MEASURE || r_op == OP_SAMPLE) begin
                    if (r_rx > r_hi_x) r_hi_x <= r_rx;
                    if (r_rx < r_lo_x) r_lo_x <= r_rx;
                    if (r_ry > r_hi_y) r_hi_y <= r_ry;
                    if (r_ry < r_lo_y) r_lo_y <= r_ry;
                end
            end
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (!i_stall)
                r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= t_op'(i_op);
            r_rx <= i_raw_x;
            r_ry <= i_raw_y;
        end
        // divider: load, step, keep the X result
        if (i_cmd.div_init_x || i_cmd.div_init_y) begin
            r_rem <= '0;
            r_quo <= '0;
        end
        if (i_cmd.div_init_x) begin
            r_num   <= scale_num(span_x, span_y);
            r_dvs   <= {span_x, 1'b0};
            r_dzero <= (span_x == 16'd0);
        end
        if (i_cmd.div_init_y) begin
            r_new_sx <= scale_sat(r_dzero, r_quo);
            r_num    <= scale_num(span_y, span_x);
            r_dvs    <= {span_y, 1'b0};
            r_dzero  <= (span_y == 16'd0);
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? 17'(rem_sh - {1'b0, r_dvs}) : rem_sh[16:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], rem_ge};
        end
        // correction: multiply, then round and saturate
        if (i_cmd.mul_x || i_cmd.mul_y)
            r_prod <= mul_a * mul_b;
        if (i_cmd.mul_y)
            r_cx <= round_sat(r_prod);
        if (i_cmd.round)
            r_cy <= round_sat(r_prod);
        // CORDIC: pre-rotate into the right half plane
        if (i_cmd.cordic_init) begin
            r_zero <= (r_cx == 18'sd0) && (r_cy == 18'sd0);
            if (r_cy < 0) begin
                r_x <= -(XY_W'(r_cy) <<< 8);
                r_y <= -(XY_W'(r_cx) <<< 8);
                r_z <= (r_cx >= 0) ? ANG_W'(1800 * 65536) : -ANG_W'(1800 * 65536);
            end else begin
                r_x <= XY_W'(r_cy) <<< 8;
                r_y <= XY_W'(r_cx) <<< 8;
                r_z <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
        // output register
        if (i_cmd.out_load) begin
            o_cal_x       <= r_cx;
            o_cal_y       <= r_cy;
            o_heading     <= h_wrap[11:0];
            o_range_min_x <= r_lo_x;
            o_range_max_x <= r_hi_x;
            o_range_min_y <= r_lo_y;
            o_range_max_y <= r_hi_y;
            o_calibrated  <= r_cal_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_stat.out_busy = r_out_valid && i_stall;

endmodule

// ===== sv/magnetometer_heading_calibrator.sv =====
// Top level of the magnetometer heading calibrator.
// Joins controller mhc_ctrl and datapath mhc_dp. Uses mhc_pkg.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_op, i_raw_x, i_raw_y
//   result    out        o_valid / i_stall   o_cal_x .. o_calibrated
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item at a time. Measure, start and sample run the correction multiplier
// and then the CORDIC iteration loop.
// Finish first runs the bit-serial scale divider, once per axis, and then
// the same steps.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds in the output register; the next item may be taken
// meanwhile and waits at its last step until the register frees.
module magnetometer_heading_calibrator
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic signed [15:0]  i_raw_x,
    input  logic signed [15:0]  i_raw_y,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [17:0]  o_cal_x,
    output logic signed [17:0]  o_cal_y,
    output logic [11:0]         o_heading,
    output logic signed [15:0]  o_range_min_x,
    output logic signed [15:0]  o_range_max_x,
    output logic signed [15:0]  o_range_min_y,
    output logic signed [15:0]  o_range_max_y,
    output logic                o_calibrated
);

    localparam int IDX_W = $clog2(CORDIC_STEPS);

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] step;

    mhc_ctrl #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_step  (step)
    );

    mhc_dp #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_cmd         (cmd),
        .i_step        (step),
        .o_stat        (stat),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_cal_x       (o_cal_x),
        .o_cal_y       (o_cal_y),
        .o_heading     (o_heading),
        .o_range_min_x (o_range_min_x),
        .o_range_max_x (o_range_max_x),
        .o_range_min_y (o_range_min_y),
        .o_range_max_y (o_range_max_y),
        .o_calibrated  (o_calibrated)
    );

endmodule

// ===== dv/tb_magnetometer_heading_calibrator.sv =====
// Testbench for the magnetometer heading calibrator: directed and random
// transactions checked against an in-bench predictor. Depends on mhc_pkg.
`timescale 1ns / 1ps

module tb_magnetometer_heading_calibrator;
    import mhc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_op;
    logic signed [15:0] i_raw_x;
    logic signed [15:0] i_raw_y;
    logic               o_valid;
    logic               i_stall;
    logic signed [17:0] o_cal_x;
    logic signed [17:0] o_cal_y;
    logic [11:0]        o_heading;
    logic signed [15:0] o_range_min_x;
    logic signed [15:0] o_range_max_x;
    logic signed [15:0] o_range_min_y;
    logic signed [15:0] o_range_max_y;
    logic               o_calibrated;

    typedef struct packed {
        logic signed [17:0] cal_x;
        logic signed [17:0] cal_y;
        logic [11:0]        heading;
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
        logic               calibrated;
    } t_reading;

    t_reading heading_queue[$];

    // predictor copy of configuration and state
    logic signed [15:0] cfg_ofs_x, cfg_ofs_y;
    logic [15:0]        cfg_scl_x, cfg_scl_y;
    logic signed [12:0] cfg_trim;
    logic               pr_done;
    logic signed [15:0] pr_ofs_x, pr_ofs_y;
    logic [15:0]        pr_scl_x, pr_scl_y;
    logic signed [15:0] pr_lo_x, pr_hi_x, pr_lo_y, pr_hi_y;

    int  error_count;
    int  idle_cycles;
    bit  no_idle;
    bit  timed_out;

    magnetometer_heading_calibrator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor division by 2^s
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint apply_iron(longint raw, longint ofs, longint scl);
        longint q;
        q = floor_shift((raw - ofs) * scl + (64'sd1 <<< (SCALE_FRAC_BITS_DEF - 1)),
                        SCALE_FRAC_BITS_DEF);
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return q;
    endfunction

    function automatic longint atan_tenths(int i);
        longint tab[24] = '{29491200, 17409672, 9198793, 4669451, 2343786, 1173036,
            586661, 293348, 146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
            573, 286, 143, 72, 36, 18, 9, 4};
        return tab[i];
    endfunction

    // vectoring CORDIC: atan2(ny, dx) in tenths of a degree
    function automatic longint vector_angle(longint ny, longint dx);
        longint x, y, z, xs, ys;
        x = dx * 256;
        y = ny * 256;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 1800 * 65536 : -1800 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += atan_tenths(i);
            end else begin
                x = x - ys; y = y + xs; z -= atan_tenths(i);
            end
        end
        return (z + 32768) >>> 16;
    endfunction

    function automatic logic [15:0] span_scale(longint d, longint e);
        longint q;
        if (d < 0) d = 0;
        if (e < 0) e = 0;
        if (d == 0) return 16'(1 << SCALE_FRAC_BITS_DEF);
        q = (((d + e) <<< SCALE_FRAC_BITS_DEF) + d) / (2 * d);
        return (q > 65535) ? 16'hFFFF : 16'(q);
    endfunction

    function automatic logic signed [15:0] midpoint(longint lo, longint hi);
        return 16'(((hi + lo + 1 + 65536) >> 1) - 32768);
    endfunction

    // advance predictor by one transaction
    function automatic t_reading predict_heading(t_op op, logic signed [15:0] rx,
                                                 logic signed [15:0] ry);
        t_reading r;
        longint ox, oy, sx, sy, cx, cy, h;
        if (op == OP_START) begin
            pr_lo_x = rx; pr_hi_x = rx; pr_lo_y = ry; pr_hi_y = ry;
        end else if (op == OP_FINISH) begin
            pr_ofs_x = midpoint(pr_lo_x, pr_hi_x);
            pr_ofs_y = midpoint(pr_lo_y, pr_hi_y);
            pr_scl_x = span_scale(longint'(pr_hi_x) - pr_lo_x, longint'(pr_hi_y) - pr_lo_y);
            pr_scl_y = span_scale(longint'(pr_hi_y) - pr_lo_y, longint'(pr_hi_x) - pr_lo_x);
            pr_done = 1'b1;
        end
        if (pr_done) begin
            ox = pr_ofs_x; oy = pr_ofs_y; sx = pr_scl_x; sy = pr_scl_y;
        end else begin
            ox = cfg_ofs_x; oy = cfg_ofs_y; sx = cfg_scl_x; sy = cfg_scl_y;
        end
        cx = apply_iron(rx, ox, sx);
        cy = apply_iron(ry, oy, sy);
        h = vector_angle(cx, cy) + cfg_trim;
        repeat (2) begin
            if (h < 0) h += 3600;
            else if (h >= 3600) h -= 3600;
        end
        if (op == OP_MEASURE || op == OP_SAMPLE) begin
            if (rx > pr_hi_x) pr_hi_x = rx;
            if (rx < pr_lo_x) pr_lo_x = rx;
            if (ry > pr_hi_y) pr_hi_y = ry;
            if (ry < pr_lo_y) pr_lo_y = ry;
        end
        r.cal_x = 18'(cx); r.cal_y = 18'(cy); r.heading = 12'(h);
        r.min_x = pr_lo_x; r.max_x = pr_hi_x; r.min_y = pr_lo_y; r.max_y = pr_hi_y;
        r.calibrated = pr_done;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // drop valid and hold a random idle burst, sometimes
    task automatic maybe_idle();
        if (!no_idle && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge i_clk);
        end
    endtask

    // valid stays high after acceptance until the next idle or drain;
    // the block is busy for the whole item, so nothing is taken twice
    task automatic send_reading(t_op op, logic [15:0] rx, logic [15:0] ry);
        maybe_idle();
        i_valid <= 1'b1;
        i_op    <= op;
        i_raw_x <= rx;
        i_raw_y <= ry;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        heading_queue.push_back(predict_heading(op, rx, ry));
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OFS_X: cfg_ofs_x = data;
            CFG_OFS_Y: cfg_ofs_y = data;
            CFG_SCL_X: cfg_scl_x = data;
            CFG_SCL_Y: cfg_scl_y = data;
            CFG_TRIM:  cfg_trim  = data[12:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // drop valid, wait for every result, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (heading_queue.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_reading(OP_MEASURE, 16'h0000, 16'h0000);
        send_reading(OP_MEASURE, 16'h7FFF, 16'h7FFF);
        send_reading(OP_MEASURE, 16'h8000, 16'h8000);
        send_reading(OP_MEASURE, 16'h8000, 16'h7FFF);
        send_reading(OP_MEASURE, 16'h0000, 16'hFF00);
        send_reading(OP_MEASURE, 16'hFF00, 16'h0000);
        send_reading(OP_MEASURE, 16'hFFFF, 16'hFFFF);
        // finish with equal full-scale ranges gives unit scale
        send_reading(OP_FINISH, 16'h1234, 16'hEDCC);
        drain();
    endtask

    task automatic test_calibration();
        send_reading(OP_START, 16'd100, 16'hFF00);
        send_reading(OP_SAMPLE, 16'd300, 16'd50);
        send_reading(OP_SAMPLE, 16'hFFF0, 16'd400);
        send_reading(OP_FINISH, 16'd10, 16'd10);
        send_reading(OP_MEASURE, 16'd200, 16'd200);
        // zero span on one axis (unit scale), then a one-count span against a huge one (saturating scale)
        send_reading(OP_START, 16'd5, 16'h8000);
        send_reading(OP_SAMPLE, 16'd5, 16'h7FFF);
        send_reading(OP_FINISH, 16'd5, 16'd0);
        send_reading(OP_START, 16'd0, 16'd0);
        send_reading(OP_SAMPLE, 16'd1, 16'h7FFF);
        send_reading(OP_FINISH, 16'd1, 16'd1);
        drain();
    endtask

    // trim extremes and large scales, before any calibration
    task automatic test_config(logic [15:0] ox, logic [15:0] oy, logic [15:0] sx,
                               logic [15:0] sy, logic [12:0] trim, int n);
        write_reg(CFG_OFS_X, ox);
        write_reg(CFG_OFS_Y, oy);
        write_reg(CFG_SCL_X, sx);
        write_reg(CFG_SCL_Y, sy);
        write_reg(CFG_TRIM, {3'b000, trim});
        repeat (n) send_reading(t_op'($urandom_range(0, 2) == 1 ? OP_SAMPLE : OP_MEASURE),
                                rand_word(), rand_word());
        drain();
    endtask

    task automatic test_random(int n);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) < 8) begin
                // well-formed calibration sequence
                send_reading(OP_START, rand_word(), rand_word());
                repeat ($urandom_range(12)) begin
                    send_reading(OP_SAMPLE, rand_word(), rand_word());
                    k++;
                end
                send_reading(OP_FINISH, rand_word(), rand_word());
                repeat ($urandom_range(6)) begin
                    send_reading(OP_MEASURE, rand_word(), rand_word());
                    k++;
                end
                k += 2;
            end else begin
                send_reading(t_op'($urandom_range(3)), rand_word(), rand_word());
                k++;
            end
        end
    endtask

    // check each result against the oldest expectation
    initial begin
        t_reading want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                idle_cycles = 0;
                if (heading_queue.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = heading_queue.pop_front();
                    if (o_cal_x !== want.cal_x) report_mismatch("cal_x", o_cal_x, want.cal_x);
                    if (o_cal_y !== want.cal_y) report_mismatch("cal_y", o_cal_y, want.cal_y);
                    if (o_heading !== want.heading)
                        report_mismatch("heading", o_heading, want.heading);
                    if (o_range_min_x !== want.min_x)
                        report_mismatch("range_min_x", o_range_min_x, want.min_x);
                    if (o_range_max_x !== want.max_x)
                        report_mismatch("range_max_x", o_range_max_x, want.max_x);
                    if (o_range_min_y !== want.min_y)
                        report_mismatch("range_min_y", o_range_min_y, want.min_y);
                    if (o_range_max_y !== want.max_y)
                        report_mismatch("range_max_y", o_range_max_y, want.max_y);
                    if (o_calibrated !== want.calibrated)
                        report_mismatch("calibrated", o_calibrated, want.calibrated);
                end
            end else if (i_valid && !o_stall) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
            end
        end
    end

    // drive receiver stall in random bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(9, 1)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // end the run on a stuck handshake
    initial begin
        wait (timed_out);
        $display("tb_magnetometer_heading_calibrator: errors");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_OFS_X; i_cfg_data = '0;
        i_valid = 1'b0; i_op = OP_MEASURE; i_raw_x = '0; i_raw_y = '0;
        error_count = 0; idle_cycles = 0; no_idle = 1'b0; timed_out = 1'b0;
        cfg_ofs_x = 0; cfg_ofs_y = 0; cfg_scl_x = 16384; cfg_scl_y = 16384; cfg_trim = 0;
        pr_done = 1'b0; pr_ofs_x = 0; pr_ofs_y = 0; pr_scl_x = 16384; pr_scl_y = 16384;
        pr_lo_x = 16'sh7FFF; pr_hi_x = 16'sh8000; pr_lo_y = 16'sh7FFF; pr_hi_y = 16'sh8000;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 13'h1FFF & -13'sd1800, 40);
        test_config(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 13'd3599, 40);
        test_config(16'h0010, 16'hFFF0, 16'd20000, 16'd9000, 13'd1234, 40);
        test_extremes();
        test_calibration();
        test_random(1200);
        drain();
        // trim changes still apply after calibration
        write_reg(CFG_TRIM, 16'(-13'sd1800) & 16'h1FFF);
        test_random(300);
        no_idle = 1'b1;
        drain();
        write_reg(CFG_TRIM, 16'd3599);
        test_random(300);
        drain();

        if (error_count == 0)
            $display("tb_magnetometer_heading_calibrator: clean");
        else
            $display("tb_magnetometer_heading_calibrator: errors");
        $finish;
    end

endmodule
